/* rtl/tbp_pkg.sv */
package tbp_pkg;

    localparam int TABLE_ENTRIES = 2048;
    localparam int HISTORY_MAX   = 11;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int HBITS_W       = 4;
    localparam int CTR_W         = 2;
    localparam int PC_W          = 32;
    localparam int CNT_W         = 32;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    typedef logic [CTR_W-1:0]       ctr_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [HISTORY_MAX-1:0] hist_t;
    typedef logic [HBITS_W-1:0]     hbits_t;

    localparam ctr_t CTR_MAX      = ctr_t'(3);
    localparam ctr_t CTR_MIN      = ctr_t'(0);
    localparam ctr_t CTR_TAKEN    = ctr_t'(2);
    localparam ctr_t CTR_PHT_INIT = ctr_t'(1);
    localparam ctr_t CTR_SEL_INIT = ctr_t'(2);

    localparam hbits_t HIST_BITS_RESET = hbits_t'(11);

    localparam logic [PADDR_W-3:0] REG_HISTORY_BITS = '0;

    typedef struct packed {
        logic [PC_W-1:0] branch_pc;
        logic            outcome_taken;
    } in_t;

    typedef struct packed {
        logic             chosen_prediction;
        logic             gshare_guess;
        logic             bimodal_guess;
        logic             choice_correct;
        logic [CNT_W-1:0] correct_total;
    } out_t;

    function automatic ctr_t ctr_train(ctr_t c, logic up);
        ctr_t r;
        r = c;
        if (up)
        begin
            if (c != CTR_MAX)
            begin
                r = ctr_t'(c + ctr_t'(1));
            end
        end
        else
        begin
            if (c != CTR_MIN)
            begin
                r = ctr_t'(c - ctr_t'(1));
            end
        end
        return r;
    endfunction

    // clamp the length to 1..HISTORY_MAX and build the mask
    function automatic hist_t hist_mask(hbits_t n);
        int    n_eff;
        hist_t m;
        n_eff = int'(n);
        if (n_eff < 1)
        begin
            n_eff = 1;
        end
        if (n_eff > HISTORY_MAX)
        begin
            n_eff = HISTORY_MAX;
        end
        for (int i = 0; i < HISTORY_MAX; i++)
        begin
            m[i] = (i < n_eff);
        end
        return m;
    endfunction

endpackage

/* rtl/tournament_branch_predictor.sv */
// Tournament branch predictor (gshare against bimodal, per-address selector) training on one
// resolved branch per beat. A branch is taken every cycle unless in_stall is high; its result
// reaches the output through the s1 stage (table read at the accepting edge) and then the result
// register, and the throughput is one branch per cycle while nothing stalls, set by the single
// read and single write port of each 2048-entry counter table, with a one-entry bypass for
// back-to-back branches that hit the same entry.
// After reset the block sweeps all three tables to their initial values and holds in_stall
// high meanwhile; history_bits may be written at any time while idle and applies from the next
// history update.
module tournament_branch_predictor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  tbp_pkg::in_t                in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output tbp_pkg::out_t               out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbp_pkg::PADDR_W-1:0] paddr,
    input  logic [tbp_pkg::PDATA_W-1:0] pwdata,
    output logic [tbp_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    import tbp_pkg::*;

    hbits_t history_bits;

    logic   clr_busy_reg;
    idx_t   clr_idx_reg;

    hist_t  hist_reg;

    logic   s1_valid_reg;
    idx_t   s1_base_reg;
    idx_t   s1_gidx_reg;
    logic   s1_taken_reg;

    logic   byp_base_hit_reg;
    logic   byp_gidx_hit_reg;
    ctr_t   byp_bim_reg;
    ctr_t   byp_gsh_reg;
    ctr_t   byp_sel_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic   out_valid_reg;
    out_t   out_data_reg;

    logic   advance;
    logic   accept;
    logic   s1_fire;
    idx_t   base;
    idx_t   gidx;

    ctr_t   rd_bim;
    ctr_t   rd_gsh;
    ctr_t   rd_sel;
    ctr_t   bc;
    ctr_t   gc;
    ctr_t   sc;
    ctr_t   bim_new;
    ctr_t   gsh_new;
    ctr_t   sel_new;
    logic   bguess;
    logic   gguess;
    logic   chosen;
    logic   bright;
    logic   gright;
    logic   right;

    logic   we;
    idx_t   waddr_base;
    idx_t   waddr_gidx;
    ctr_t   wdata_bim;
    ctr_t   wdata_gsh;
    ctr_t   wdata_sel;

    tbp_apb u_apb (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .history_bits (history_bits)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = clr_busy_reg || !advance;
    assign accept   = in_valid && !in_stall;
    assign s1_fire  = s1_valid_reg && advance;

    assign base = in_data.branch_pc[IDX_W-1:0];
    assign gidx = base ^ IDX_W'(hist_reg);

    // sweep the tables after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= idx_t'(clr_idx_reg + idx_t'(1));
            if (clr_idx_reg == idx_t'(TABLE_ENTRIES - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (accept)
        begin
            hist_reg <= {hist_reg[HISTORY_MAX-2:0], in_data.outcome_taken}
                        & hist_mask(history_bits);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_base_reg  <= base;
            s1_gidx_reg  <= gidx;
            s1_taken_reg <= in_data.outcome_taken;
        end
    end

    // catch the entry written in the same cycle as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_base_hit_reg <= 1'b0;
            byp_gidx_hit_reg <= 1'b0;
        end
        else if (advance)
        begin
            byp_base_hit_reg <= accept && s1_valid_reg && (base == s1_base_reg);
            byp_gidx_hit_reg <= accept && s1_valid_reg && (gidx == s1_gidx_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byp_bim_reg <= bim_new;
            byp_gsh_reg <= gsh_new;
            byp_sel_reg <= sel_new;
        end
    end

    tbp_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_bim_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr_base),
        .wdata (wdata_bim),
        .re    (accept),
        .raddr (base),
        .rdata (rd_bim)
    );

    tbp_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_gsh_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr_gidx),
        .wdata (wdata_gsh),
        .re    (accept),
        .raddr (gidx),
        .rdata (rd_gsh)
    );

    tbp_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_sel_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr_base),
        .wdata (wdata_sel),
        .re    (accept),
        .raddr (base),
        .rdata (rd_sel)
    );

    always_comb
    begin
        bc = byp_base_hit_reg ? byp_bim_reg : rd_bim;
        gc = byp_gidx_hit_reg ? byp_gsh_reg : rd_gsh;
        sc = byp_base_hit_reg ? byp_sel_reg : rd_sel;

        bguess = (bc >= CTR_TAKEN);
        gguess = (gc >= CTR_TAKEN);
        chosen = (sc < CTR_TAKEN) ? gguess : bguess;
        bright = (bguess == s1_taken_reg);
        gright = (gguess == s1_taken_reg);
        right  = (chosen == s1_taken_reg);

        bim_new = ctr_train(bc, s1_taken_reg);
        gsh_new = ctr_train(gc, s1_taken_reg);
        sel_new = sc;
        if (bright && !gright)
        begin
            sel_new = ctr_train(sc, 1'b1);
        end
        else if (gright && !bright)
        begin
            sel_new = ctr_train(sc, 1'b0);
        end

        cnt_next = cnt_reg;
        if (right && (cnt_reg != '1))
        begin
            cnt_next = CNT_W'(cnt_reg + CNT_W'(1));
        end
    end

    always_comb
    begin
        we = s1_fire || clr_busy_reg;
        if (clr_busy_reg)
        begin
            waddr_base = clr_idx_reg;
            waddr_gidx = clr_idx_reg;
            wdata_bim  = CTR_PHT_INIT;
            wdata_gsh  = CTR_PHT_INIT;
            wdata_sel  = CTR_SEL_INIT;
        end
        else
        begin
            waddr_base = s1_base_reg;
            waddr_gidx = s1_gidx_reg;
            wdata_bim  = bim_new;
            wdata_gsh  = gsh_new;
            wdata_sel  = sel_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (s1_fire)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg.chosen_prediction <= chosen;
            out_data_reg.gshare_guess      <= gguess;
            out_data_reg.bimodal_guess     <= bguess;
            out_data_reg.choice_correct    <= right;
            out_data_reg.correct_total     <= cnt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/tbp_ram.sv */
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tbp_apb.sv */
module tbp_apb (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tbp_pkg::PADDR_W-1:0]  paddr,
    input  logic [tbp_pkg::PDATA_W-1:0]  pwdata,
    output logic [tbp_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output tbp_pkg::hbits_t              history_bits
);

    import tbp_pkg::*;

    hbits_t hist_bits_reg;
    logic   reg_sel;

    assign reg_sel = (paddr[PADDR_W-1:2] == REG_HISTORY_BITS);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_bits_reg <= HIST_BITS_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            hist_bits_reg <= pwdata[HBITS_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = PDATA_W'(hist_bits_reg);
        end
    end

    assign history_bits = hist_bits_reg;

endmodule
